[rtl/sap_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_pkg
// shared types and constants of the shelf atlas packer
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int unsigned GlyphW = 14;
  localparam int unsigned EdgeW  = 15;

  // reset value of the padding register, also the cursor reset value
  localparam logic [7:0]  PadRst   = 8'd2;
  localparam logic [14:0] LimRst   = 15'd4096;
  localparam logic [14:0] MinPage  = 15'd64;

  typedef enum logic [2:0] {
    STAT_PLACED  = 3'd0,
    STAT_CLOSED  = 3'd1,
    STAT_SKIPPED = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_TOOBIG  = 3'd4,
    STAT_LIMIT   = 3'd5,
    STAT_FAILED  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    REG_PADDING     = 2'd0,
    REG_ATLAS_LIMIT = 2'd1,
    REG_SFX_MODE    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CHECK = 2'd1,
    S_FIT   = 2'd2
  } state_e;

  typedef struct packed {
    logic [7:0]  padding;
    logic [14:0] atlas_limit;
    logic        sfx_mode;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    latch_fit;
    logic    emit;
    status_e emit_status;
    logic    emit_last;
    logic    do_place;
    logic    do_close;
    logic    set_fail;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic failed;
    logic op_close;
    logic has_glyphs;
    logic skip;
    logic too_big;
    logic at_limit;
    logic fits;
  } sts_t;

endpackage

[rtl/sap_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_cfg
// configuration registers behind a simple apb slave
// ----------------------------------------------------------------------------
module sap_cfg
  import sap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.padding     <= PadRst;
      cfg_q.atlas_limit <= LimRst;
      cfg_q.sfx_mode    <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_PADDING:     cfg_q.padding     <= pwdata[7:0];
        REG_ATLAS_LIMIT: cfg_q.atlas_limit <= pwdata[14:0];
        REG_SFX_MODE:    cfg_q.sfx_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PADDING:     prdata = {24'd0, cfg_q.padding};
      REG_ATLAS_LIMIT: prdata = {17'd0, cfg_q.atlas_limit};
      REG_SFX_MODE:    prdata = {31'd0, cfg_q.sfx_mode};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

[rtl/sap_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_ctrl
// sequencer: accept, check, fit, with one retry after a page close
// ----------------------------------------------------------------------------
module sap_ctrl
  import sap_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   retry_q, retry_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      retry_q <= 1'b0;
    end else begin
      state_q <= state_d;
      retry_q <= retry_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    retry_d    = retry_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.emit_status = STAT_PLACED;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          retry_d       = 1'b0;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.out_free) begin
          state_d         = S_IDLE;
          cmd_o.emit_last = 1'b1;
          if (sts_i.failed) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = STAT_FAILED;
          end else if (sts_i.op_close) begin
            cmd_o.emit = 1'b1;
            if (!sts_i.has_glyphs) begin
              cmd_o.emit_status = STAT_EMPTY;
            end else if (sts_i.at_limit) begin
              cmd_o.emit_status = STAT_LIMIT;
              cmd_o.set_fail    = 1'b1;
            end else begin
              cmd_o.emit_status = STAT_CLOSED;
              cmd_o.do_close    = 1'b1;
            end
          end else if (sts_i.skip) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = STAT_SKIPPED;
          end else if (sts_i.too_big) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = STAT_TOOBIG;
            cmd_o.set_fail    = 1'b1;
          end else begin
            cmd_o.latch_fit = 1'b1;
            state_d         = S_FIT;
          end
        end
      end
      S_FIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
          if (sts_i.fits) begin
            cmd_o.emit_status = STAT_PLACED;
            cmd_o.do_place    = 1'b1;
          end else if (!sts_i.has_glyphs || retry_q) begin
            cmd_o.emit_status = STAT_TOOBIG;
            cmd_o.set_fail    = 1'b1;
          end else if (sts_i.at_limit) begin
            cmd_o.emit_status = STAT_LIMIT;
            cmd_o.set_fail    = 1'b1;
          end else begin
            // page full: close it, then try again on the fresh page
            cmd_o.emit_status = STAT_CLOSED;
            cmd_o.emit_last   = 1'b0;
            cmd_o.do_close    = 1'b1;
            retry_d           = 1'b1;
            state_d           = S_CHECK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[rtl/sap_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_dp
// page state per role, placement arithmetic and result register
// ----------------------------------------------------------------------------
module sap_dp
  import sap_pkg::*;
#(
  parameter int HARD_LIMIT = 16384,
  parameter int MAX_PAGES  = 16,
  parameter int ROLE_COUNT = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  // item fields
  input  logic              in_op_i,
  input  logic              in_role_i,
  input  logic [GlyphW-1:0] in_w_i,
  input  logic [GlyphW-1:0] in_h_i,
  input  logic              in_df_i,
  // result register
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output status_e           out_status_o,
  output logic              out_role_o,
  output logic [13:0]       out_x_o,
  output logic [13:0]       out_y_o,
  output logic [7:0]        out_page_o,
  output logic [EdgeW-1:0]  out_pw_o,
  output logic [EdgeW-1:0]  out_ph_o,
  output logic              out_last_o
);

  localparam logic [14:0] HardLim = 15'(HARD_LIMIT);
  localparam logic [8:0]  PageMax = 9'(MAX_PAGES);
  localparam logic        RoleTop = 1'(ROLE_COUNT - 1);

  function automatic logic [14:0] sat15(input logic [17:0] v);
    sat15 = (v > 18'h7FFF) ? 15'h7FFF : v[14:0];
  endfunction

  // smallest power of two from 64 that covers v (v is at most 16384)
  function automatic logic [14:0] page_round(input logic [14:0] v);
    logic [14:0] res;
    res = 15'd16384;
    for (int k = 13; k >= 6; k--) begin
      if (v <= 15'(1 << k)) res = 15'(1 << k);
    end
    page_round = res;
  endfunction

  // per-role page state
  logic [14:0] cx_q [ROLE_COUNT];
  logic [14:0] cy_q [ROLE_COUNT];
  logic [14:0] sh_q [ROLE_COUNT];
  logic [14:0] uw_q [ROLE_COUNT];
  logic [14:0] uh_q [ROLE_COUNT];
  logic        hg_q [ROLE_COUNT];
  logic [8:0]  pd_q [ROLE_COUNT];
  logic        fail_q;

  // latched item
  logic              op_q, role_q, df_q;
  logic [GlyphW-1:0] w_q, h_q;
  logic              role_c;

  // fit stage
  logic [14:0] xs_q, shs_q;
  logic [16:0] ys_q;

  logic [7:0]  pad;
  logic [8:0]  pad2;
  logic [14:0] lim;
  logic [15:0] w_pad2, h_pad2;
  logic [16:0] fx, yw;
  logic        wrap;
  logic [17:0] yb, xn;
  logic [16:0] xe;
  logic [14:0] tall, cur_sh, cur_uw, cur_uh;
  logic [14:0] uw_c, uh_c;
  logic [8:0]  cur_pd;

  logic             out_valid_q;
  logic             out_free;
  logic             is_placed, is_closed;
  status_e          out_status_q;
  logic             out_role_q;
  logic [13:0]      out_x_q, out_y_q;
  logic [7:0]       out_page_q;
  logic [EdgeW-1:0] out_pw_q, out_ph_q;
  logic             out_last_q;

  assign role_c = (int'(in_role_i) >= ROLE_COUNT) ? RoleTop : in_role_i;

  assign pad    = cfg_i.padding;
  assign pad2   = {pad, 1'b0};
  assign lim    = (cfg_i.atlas_limit < HardLim) ? cfg_i.atlas_limit : HardLim;
  assign w_pad2 = 16'(w_q) + 16'(pad2);
  assign h_pad2 = 16'(h_q) + 16'(pad2);

  assign cur_sh = sh_q[role_q];
  assign cur_uw = uw_q[role_q];
  assign cur_uh = uh_q[role_q];
  assign cur_pd = pd_q[role_q];

  // check stage: wrap onto a new shelf when the row is used up
  assign fx   = 17'(cx_q[role_q]) + 17'(w_q) + 17'(pad);
  assign wrap = fx > 17'(lim);
  assign yw   = 17'(cy_q[role_q]) + 17'(cur_sh);

  // fit stage
  assign yb   = 18'(ys_q) + 18'(h_q) + 18'(pad);
  assign xe   = 17'(xs_q) + 17'(w_q) + 17'(pad);
  assign xn   = 18'(xs_q) + 18'(w_q) + 18'(pad2);
  assign tall = 15'(h_q) + 15'(pad2);

  assign uw_c = (cur_uw > HardLim) ? HardLim : cur_uw;
  assign uh_c = (cur_uh > HardLim) ? HardLim : cur_uh;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.out_free   = out_free;
    sts_o.failed     = fail_q;
    sts_o.op_close   = op_q;
    sts_o.has_glyphs = hg_q[role_q];
    sts_o.skip       = (w_q == '0) || (h_q == '0) || (df_q != cfg_i.sfx_mode);
    sts_o.too_big    = (lim < MinPage) || (w_pad2 > 16'(lim)) || (h_pad2 > 16'(lim));
    sts_o.at_limit   = cur_pd >= PageMax;
    sts_o.fits       = yb <= 18'(lim);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= in_op_i;
      role_q <= role_c;
      w_q    <= in_w_i;
      h_q    <= in_h_i;
      df_q   <= in_df_i;
    end
    if (cmd_i.latch_fit) begin
      xs_q  <= wrap ? 15'(pad) : cx_q[role_q];
      ys_q  <= wrap ? yw : 17'(cy_q[role_q]);
      shs_q <= wrap ? 15'd0 : cur_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROLE_COUNT; r++) begin
        cx_q[r] <= 15'(PadRst);
        cy_q[r] <= 15'(PadRst);
        sh_q[r] <= '0;
        uw_q[r] <= '0;
        uh_q[r] <= '0;
        hg_q[r] <= 1'b0;
        pd_q[r] <= '0;
      end
      fail_q <= 1'b0;
    end else begin
      if (cmd_i.set_fail) fail_q <= 1'b1;
      if (cmd_i.do_close) begin
        cx_q[role_q] <= 15'(pad);
        cy_q[role_q] <= 15'(pad);
        sh_q[role_q] <= '0;
        uw_q[role_q] <= '0;
        uh_q[role_q] <= '0;
        hg_q[role_q] <= 1'b0;
        pd_q[role_q] <= cur_pd + 9'd1;
      end else if (cmd_i.do_place) begin
        cx_q[role_q] <= sat15(xn);
        cy_q[role_q] <= sat15(18'(ys_q));
        sh_q[role_q] <= (shs_q > tall) ? shs_q : tall;
        if (xe > 17'(cur_uw)) uw_q[role_q] <= sat15(18'(xe));
        if (yb > 18'(cur_uh)) uh_q[role_q] <= sat15(yb);
        hg_q[role_q] <= 1'b1;
      end
    end
  end

  // result register
  assign is_placed = cmd_i.emit_status == STAT_PLACED;
  assign is_closed = cmd_i.emit_status == STAT_CLOSED;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_role_q   <= role_q;
      out_x_q      <= is_placed ? xs_q[13:0] : 14'd0;
      out_y_q      <= is_placed ? ys_q[13:0] : 14'd0;
      out_page_q   <= (is_placed || is_closed) ? cur_pd[7:0] : 8'd0;
      out_pw_q     <= is_closed ? page_round(uw_c) : 15'd0;
      out_ph_q     <= is_closed ? page_round(uh_c) : 15'd0;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_role_o   = out_role_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_page_o   = out_page_q;
  assign out_pw_o     = out_pw_q;
  assign out_ph_o     = out_ph_q;
  assign out_last_o   = out_last_q;

endmodule

[rtl/shelf_atlas_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shelf_atlas_packer
// shelf packing of glyph rectangles onto atlas pages, one page
// state per byte role
// ----------------------------------------------------------------------------
//
// channel   direction  carries
// s_axis    in         place or close request (size, role, mask kind)
// m_axis    out        status, position, closed page size; tlast on final
// apb       in/out     padding, atlas_limit, shader_effects_mode
//
// an item is taken in the idle state and answered from the check state
// (failed earlier, skip, close request, oversize) or from check then fit
// (placement, or a glyph that the page cannot take); a placement that first
// closes a full page runs check and fit twice. the check/fit sequencer works
// on one item at a time
// a result waiting in the output register does not block the next transaction
// on s_axis; the sequencer only holds in check or fit while that register is
// still occupied
// reset is asynchronous, active low; no clearing pass, state is ready at once
//
module shelf_atlas_packer
  import sap_pkg::*;
#(
  parameter int HARD_LIMIT = 16384,
  parameter int MAX_PAGES  = 16,
  parameter int ROLE_COUNT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // glyph_width[13:0], glyph_height[27:14]
  input  logic [2:0]  s_axis_tuser,  // operation[0], role[1], is_distance_field[2]
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pos_x[13:0], pos_y[27:14], page_index[35:28], page_width[50:36],
  // page_height[65:51]
  output logic [71:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,  // status[2:0], out_role[3]
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  sts_t    sts;
  status_e res_status;
  logic    res_role;
  logic [13:0] res_x, res_y;
  logic [7:0]  res_page;
  logic [14:0] res_pw, res_ph;

  // register file
  sap_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: decides which result goes out and which state changes
  sap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // page state, placement arithmetic, result register
  sap_dp #(
    .HARD_LIMIT (HARD_LIMIT),
    .MAX_PAGES  (MAX_PAGES),
    .ROLE_COUNT (ROLE_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser[0]),
    .in_role_i    (s_axis_tuser[1]),
    .in_w_i       (s_axis_tdata[13:0]),
    .in_h_i       (s_axis_tdata[27:14]),
    .in_df_i      (s_axis_tuser[2]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (res_status),
    .out_role_o   (res_role),
    .out_x_o      (res_x),
    .out_y_o      (res_y),
    .out_page_o   (res_page),
    .out_pw_o     (res_pw),
    .out_ph_o     (res_ph),
    .out_last_o   (m_axis_tlast)
  );

  // pack the result fields, low field first, zero fill to whole bytes
  assign m_axis_tdata = {6'd0, res_ph, res_pw, res_page, res_y, res_x};
  assign m_axis_tuser = {res_role, res_status};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // the failure flag is sticky
  a_fail_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.failed |=> sts.failed)
    else $error("failure flag cleared");

  // only a page close ahead of a retried placement leaves tlast low
  a_last_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (res_status == STAT_CLOSED))
    else $error("non-final result that is not a page close");

  // a failed-earlier answer needs the flag to be set
  a_failed_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_status == STAT_FAILED) |-> sts.failed)
    else $error("failed status without failure flag");

  // a closed page always lies below the page limit
  a_close_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_status == STAT_CLOSED) |-> (9'(res_page) < 9'(MAX_PAGES)))
    else $error("closed page index beyond page limit");

endmodule

[verif/shelf_atlas_packer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shelf_atlas_packer_test
// self-checking bench for the shelf atlas packer: a short hand-written table
// of requests, then phases of random placements and closes under changing
// padding, edge limit and mask mode, each checked field by field against a
// shelf packing predictor kept in step with every accepted transaction; the
// run ends with one sticky error (chosen at random) and the failed-state
// replies that follow it
// ----------------------------------------------------------------------------
module shelf_atlas_packer_test
  import sap_pkg::*;
();

  localparam int HardLimit = 16384;
  localparam int MaxPages  = 16;
  // pages a role may close during the random phases, the rest is kept for
  // the page limit at the end
  localparam int CloseCeil = 14;

  localparam logic OpPlace = 1'b0;
  localparam logic OpClose = 1'b1;

  // one request on s_axis
  typedef struct packed {
    logic        op;
    logic        role;
    logic [13:0] width;
    logic [13:0] height;
    logic        dist_field;
  } glyph_t;

  // one reply on m_axis
  typedef struct packed {
    status_e     status;
    logic        role;
    logic [13:0] pos_x;
    logic [13:0] pos_y;
    logic [7:0]  page;
    logic [14:0] page_w;
    logic [14:0] page_h;
    logic        last;
  } result_t;

  // packer state, one slot per role
  typedef struct packed {
    logic [1:0][14:0] cur_x, cur_y, shelf, used_w, used_h;
    logic [1:0]       has_glyphs;
    logic [1:0][8:0]  pages;
    logic             failed;
  } pack_state_t;

  // hand-written request; typed rows carry the reply that is read off at a
  // glance (page 0, no page size, last set), the others use the predictor
  typedef struct packed {
    logic        op;
    logic        role;
    logic [13:0] width;
    logic [13:0] height;
    logic        dist_field;
    logic        typed;
    status_e     status;
    logic [13:0] pos_x;
    logic [13:0] pos_y;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // glyph_width[13:0], glyph_height[27:14]
  logic [2:0]  s_axis_tuser = '0;  // operation[0], role[1], is_distance_field[2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pos_x[13:0], pos_y[27:14], page_index[35:28], page_width[50:36],
  // page_height[65:51]
  logic [71:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;       // status[2:0], out_role[3]
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  shelf_atlas_packer #(
    .HARD_LIMIT(HardLimit),
    .MAX_PAGES (MaxPages),
    .ROLE_COUNT(2)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copies of the registers and the page state
  cfg_t        knobs;
  pack_state_t pk;
  result_t     packer_replies[$];   // replies still owed by the block
  result_t     oldest_reply;
  int          close_cap[2];
  int          mismatch_count = 0;
  int          reply_count = 0;

  // idling control; calm switches all idling off for the closing stretch
  int          tx_idle_pct = 10;
  int          rx_stall_pct = 10;
  bit          calm = 1'b0;
  int          rx_hold = 0;

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch: reply %0d: %s", reply_count, msg);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // appends one owed reply at the tail of the queue
  task automatic book_reply(result_t rs);
    packer_replies = {packer_replies, rs};
  endtask

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  function automatic logic [14:0] sat15(int v);
    return (v > 32767) ? 15'h7fff : 15'(v);
  endfunction

  // closed page edge: power of two from 64, at most the hard limit
  function automatic int page_edge(int used);
    int want;
    int e;
    want = (used < 64) ? 64 : used;
    e = 64;
    while (e < want && e < HardLimit) e = e << 1;
    return e;
  endfunction

  function automatic result_t mk_res(status_e st, int r, int x, int y, int pg,
                                     int pw, int ph, bit last_f);
    result_t o;
    o.status = st;
    o.role   = 1'(r);
    o.pos_x  = 14'(x);
    o.pos_y  = 14'(y);
    o.page   = 8'(pg);
    o.page_w = 15'(pw);
    o.page_h = 15'(ph);
    o.last   = last_f;
    return o;
  endfunction

  function automatic void clear_role(int r);
    pk.cur_x[r]      = 15'(knobs.padding);
    pk.cur_y[r]      = 15'(knobs.padding);
    pk.shelf[r]      = '0;
    pk.used_w[r]     = '0;
    pk.used_h[r]     = '0;
    pk.has_glyphs[r] = 1'b0;
  endfunction

  // closes the role's page, or returns 0 when the page count is used up
  function automatic bit close_role(int r, bit last_f, output result_t rs);
    rs = '0;
    if (int'(pk.pages[r]) >= MaxPages) return 1'b0;
    rs = mk_res(STAT_CLOSED, r, 0, 0, int'(pk.pages[r]), page_edge(int'(pk.used_w[r])),
                page_edge(int'(pk.used_h[r])), last_f);
    pk.pages[r] = pk.pages[r] + 9'd1;
    clear_role(r);
    return 1'b1;
  endfunction

  // one request through the shelf packer; returns the number of replies
  function automatic int shelf_pack(glyph_t g, output result_t [1:0] res);
    int r, w, h, p, lim, x, y, shelf, tall, n;
    result_t cr;
    res = '0;
    n = 0;
    r = int'(g.role);
    w = int'(g.width);
    h = int'(g.height);
    if (pk.failed) begin
      res[0] = mk_res(STAT_FAILED, r, 0, 0, 0, 0, 0, 1'b1);
      return 1;
    end
    if (g.op == OpClose) begin
      if (!pk.has_glyphs[r]) begin
        res[0] = mk_res(STAT_EMPTY, r, 0, 0, 0, 0, 0, 1'b1);
      end else if (close_role(r, 1'b1, cr)) begin
        res[0] = cr;
      end else begin
        pk.failed = 1'b1;
        res[0] = mk_res(STAT_LIMIT, r, 0, 0, 0, 0, 0, 1'b1);
      end
      return 1;
    end
    if (w == 0 || h == 0 || (knobs.sfx_mode ? !g.dist_field : g.dist_field)) begin
      res[0] = mk_res(STAT_SKIPPED, r, 0, 0, 0, 0, 0, 1'b1);
      return 1;
    end
    p = int'(knobs.padding);
    lim = (int'(knobs.atlas_limit) < HardLimit) ? int'(knobs.atlas_limit) : HardLimit;
    if (lim < 64 || w + 2 * p > lim || h + 2 * p > lim) begin
      pk.failed = 1'b1;
      res[0] = mk_res(STAT_TOOBIG, r, 0, 0, 0, 0, 0, 1'b1);
      return 1;
    end
    for (int attempt = 0; attempt < 2; attempt++) begin
      x = int'(pk.cur_x[r]);
      y = int'(pk.cur_y[r]);
      shelf = int'(pk.shelf[r]);
      // no room left on the shelf: open a new one below it
      if (x + w + p > lim) begin
        x = p;
        y = y + shelf;
        shelf = 0;
      end
      // no room below: close the page and retry on a fresh one
      if (y + h + p > lim) begin
        if (!pk.has_glyphs[r] || attempt != 0) begin
          pk.failed = 1'b1;
          res[n] = mk_res(STAT_TOOBIG, r, 0, 0, 0, 0, 0, 1'b1);
          return n + 1;
        end
        if (!close_role(r, 1'b0, cr)) begin
          pk.failed = 1'b1;
          res[n] = mk_res(STAT_LIMIT, r, 0, 0, 0, 0, 0, 1'b1);
          return n + 1;
        end
        res[n] = cr;
        n++;
        continue;
      end
      res[n] = mk_res(STAT_PLACED, r, x, y, int'(pk.pages[r]), 0, 0, 1'b1);
      pk.cur_x[r] = sat15(x + w + 2 * p);
      pk.cur_y[r] = sat15(y);
      tall = h + 2 * p;
      pk.shelf[r] = sat15((shelf > tall) ? shelf : tall);
      if (x + w + p > int'(pk.used_w[r])) pk.used_w[r] = sat15(x + w + p);
      if (y + h + p > int'(pk.used_h[r])) pk.used_h[r] = sat15(y + h + p);
      pk.has_glyphs[r] = 1'b1;
      return n + 1;
    end
    pk.failed = 1'b1;
    res[n] = mk_res(STAT_TOOBIG, r, 0, 0, 0, 0, 0, 1'b1);
    return n + 1;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  function automatic glyph_t glyph(logic op, logic role, int w, int h, logic df);
    glyph_t g;
    g.op = op;
    g.role = role;
    g.width = 14'(w);
    g.height = 14'(h);
    g.dist_field = df;
    return g;
  endfunction

  // drives one transaction, waits for it to be taken and books its replies
  task automatic send_glyph(glyph_t g, bit use_typed, result_t typed_res);
    result_t [1:0] res;
    int n;
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, g.height, g.width};
    s_axis_tuser  <= {g.dist_field, g.role, g.op};
    do @(posedge clk_i); while (!s_axis_tready);
    n = shelf_pack(g, res);
    if (use_typed) begin
      book_reply(typed_res);
    end else begin
      for (int i = 0; i < n; i++) book_reply(res[i]);
    end
  endtask

  // stops requests and waits until every owed reply has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (packer_replies.size() != 0);
  endtask

  // apb write followed by a read back of the same register
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PADDING:     knobs.padding = val[7:0];
      REG_ATLAS_LIMIT: knobs.atlas_limit = val[14:0];
      REG_SFX_MODE:    knobs.sfx_mode = val[0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PADDING:     want = {24'b0, knobs.padding};
      REG_ATLAS_LIMIT: want = {17'b0, knobs.atlas_limit};
      REG_SFX_MODE:    want = {31'b0, knobs.sfx_mode};
      default:         want = '0;
    endcase
    if (prdata !== want)
      flag_mismatch($sformatf("register %s reads %0h want %0h", idx.name(), prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // new register setting, only with the block idle
  task automatic set_knobs(int pad, int lim, int mode);
    wait_drained();
    write_reg(REG_PADDING, 32'(pad));
    write_reg(REG_ATLAS_LIMIT, 32'(lim));
    write_reg(REG_SFX_MODE, 32'(mode));
    for (int r = 0; r < 2; r++)
      close_cap[r] = (int'(pk.pages[r]) + 2 < CloseCeil) ? int'(pk.pages[r]) + 2 : CloseCeil;
  endtask

  // random request that keeps the packer out of the sticky failure and within
  // this phase's share of page closes; mostly fitting placements
  task automatic pick_glyph(output glyph_t g);
    glyph_t c;
    pack_state_t saved;
    result_t [1:0] scratch;
    int lim, room, k;
    bit good;
    good = 1'b0;
    c = '0;
    lim = (int'(knobs.atlas_limit) < HardLimit) ? int'(knobs.atlas_limit) : HardLimit;
    room = lim - 2 * int'(knobs.padding);
    if (room < 1) room = 64;
    if (room > 16383) room = 16383;
    for (int tries = 0; tries < 8 && !good; tries++) begin
      k = $urandom_range(0, 99);
      c.op = OpPlace;
      c.role = 1'($urandom);
      c.dist_field = knobs.sfx_mode;
      if (k < 4) begin
        c = glyph(OpClose, 1'($urandom), $urandom, $urandom, 1'($urandom));
      end else if (k < 12) begin
        // skipped placements: empty size or the mask kind the mode refuses
        c.width = 14'($urandom);
        c.height = 14'($urandom);
        case ($urandom_range(0, 2))
          0: c.width = '0;
          1: c.height = '0;
          default: c.dist_field = !knobs.sfx_mode;
        endcase
      end else if (k < 90) begin
        c.width = 14'($urandom_range(1, (room / 8 > 1) ? room / 8 : 1));
        c.height = 14'($urandom_range(1, (room / 8 > 1) ? room / 8 : 1));
      end else begin
        c.width = 14'($urandom_range(1, room));
        c.height = 14'($urandom_range(1, room));
      end
      saved = pk;
      void'(shelf_pack(c, scratch));
      good = !pk.failed && int'(pk.pages[c.role]) <= close_cap[c.role];
      pk = saved;
    end
    if (!good) c = glyph(OpPlace, 1'($urandom), 0, $urandom, 1'($urandom));
    g = c;
  endtask

  // places and closes tiny pages on one role until its page count is used up
  task automatic fill_pages(logic r);
    while (!pk.failed && int'(pk.pages[r]) < MaxPages) begin
      if (!pk.has_glyphs[r]) send_glyph(glyph(OpPlace, r, 1, 1, knobs.sfx_mode), 1'b0, '0);
      send_glyph(glyph(OpClose, r, 0, 0, 1'b0), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // reply side
  // --------------------------------------------------------------------------

  // random stall bursts on the reply side
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
      rx_hold <= $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // every reply against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reply_count++;
      if (packer_replies.size() == 0) begin
        flag_mismatch("reply with nothing outstanding");
      end else begin
        oldest_reply = packer_replies.pop_front();
        check_field("status", m_axis_tuser[2:0], oldest_reply.status);
        check_field("role", m_axis_tuser[3], oldest_reply.role);
        check_field("pos_x", m_axis_tdata[13:0], oldest_reply.pos_x);
        check_field("pos_y", m_axis_tdata[27:14], oldest_reply.pos_y);
        check_field("page_index", m_axis_tdata[35:28], oldest_reply.page);
        check_field("page_width", m_axis_tdata[50:36], oldest_reply.page_w);
        check_field("page_height", m_axis_tdata[65:51], oldest_reply.page_h);
        check_field("last", m_axis_tlast, oldest_reply.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // reset values: padding 2, edge limit 4096, plain masks only
  dir_row_t dir_table [16] = '{
    // empty pages have nothing to close, whatever the size fields hold
    '{OpClose, 1'b0, 14'd0, 14'd0, 1'b0, 1'b1, STAT_EMPTY, 14'd0, 14'd0},
    '{OpClose, 1'b1, 14'd16383, 14'd16383, 1'b1, 1'b1, STAT_EMPTY, 14'd0, 14'd0},
    // empty glyphs and refused mask kinds are skipped
    '{OpPlace, 1'b0, 14'd0, 14'd5, 1'b0, 1'b1, STAT_SKIPPED, 14'd0, 14'd0},
    '{OpPlace, 1'b1, 14'd16383, 14'd0, 1'b0, 1'b1, STAT_SKIPPED, 14'd0, 14'd0},
    '{OpPlace, 1'b0, 14'd10, 14'd10, 1'b1, 1'b1, STAT_SKIPPED, 14'd0, 14'd0},
    '{OpPlace, 1'b0, 14'd16383, 14'd16383, 1'b1, 1'b1, STAT_SKIPPED, 14'd0, 14'd0},
    // first glyph of each role lands at the padding corner
    '{OpPlace, 1'b0, 14'd10, 14'd10, 1'b0, 1'b1, STAT_PLACED, 14'd2, 14'd2},
    '{OpPlace, 1'b0, 14'd1, 14'd1, 1'b0, 1'b0, STAT_PLACED, 14'd0, 14'd0},
    '{OpPlace, 1'b1, 14'd4092, 14'd1, 1'b0, 1'b1, STAT_PLACED, 14'd2, 14'd2},
    // full shelf opens a new one
    '{OpPlace, 1'b1, 14'd1, 14'd1, 1'b0, 1'b0, STAT_PLACED, 14'd0, 14'd0},
    '{OpPlace, 1'b0, 14'd4000, 14'd3000, 1'b0, 1'b0, STAT_PLACED, 14'd0, 14'd0},
    // full page is closed first, then the glyph goes on a fresh page
    '{OpPlace, 1'b0, 14'd100, 14'd2000, 1'b0, 1'b0, STAT_PLACED, 14'd0, 14'd0},
    '{OpClose, 1'b0, 14'd0, 14'd0, 1'b0, 1'b0, STAT_CLOSED, 14'd0, 14'd0},
    '{OpClose, 1'b0, 14'd0, 14'd0, 1'b0, 1'b1, STAT_EMPTY, 14'd0, 14'd0},
    '{OpClose, 1'b1, 14'd0, 14'd0, 1'b0, 1'b0, STAT_CLOSED, 14'd0, 14'd0},
    '{OpPlace, 1'b1, 14'd1, 14'd4092, 1'b0, 1'b0, STAT_PLACED, 14'd0, 14'd0}
  };

  // fixed phases: extremes of padding and edge limit, both mask modes
  int phase_pad  [5] = '{0, 255, 1, 0, 7};
  int phase_lim  [5] = '{16384, 4096, 64, 0, 32767};
  int phase_mode [5] = '{0, 1, 0, 0, 1};
  int phase_len  [5] = '{320, 260, 260, 40, 260};
  int phase_tx   [5] = '{10, 0, 15, 10, 5};
  int phase_rx   [5] = '{10, 0, 5, 10, 20};

  initial begin
    glyph_t g;
    dir_row_t row;
    int items;
    int ending;
    logic er;

    knobs.padding = PadRst;
    knobs.atlas_limit = LimRst;
    knobs.sfx_mode = 1'b0;
    pk = '0;
    for (int r = 0; r < 2; r++) clear_role(r);
    close_cap[0] = CloseCeil;
    close_cap[1] = CloseCeil;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-written part, straight after reset
    foreach (dir_table[i]) begin
      row = dir_table[i];
      send_glyph(glyph(row.op, row.role, row.width, row.height, row.dist_field), row.typed,
                 mk_res(row.status, row.role, row.pos_x, row.pos_y, 0, 0, 0, 1'b1));
    end

    // random phases, two of them with random settings
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 5) begin
        tx_idle_pct = phase_tx[ph];
        rx_stall_pct = phase_rx[ph];
        items = phase_len[ph];
        set_knobs(phase_pad[ph], phase_lim[ph], phase_mode[ph]);
      end else begin
        tx_idle_pct = $urandom_range(0, 20);
        rx_stall_pct = $urandom_range(0, 20);
        items = 330;
        set_knobs($urandom_range(0, 255), $urandom_range(64, 16384), $urandom_range(0, 1));
      end
      repeat (items) begin
        pick_glyph(g);
        send_glyph(g, 1'b0, '0);
      end
    end

    // closing stretch: no idling, one sticky error, then failed-state replies
    calm = 1'b1;
    er = 1'($urandom);
    ending = $urandom_range(0, 4);
    set_knobs(2, 4096, 0);
    case (ending)
      0: begin
        // glyph plus padding wider than the edge limit
        send_glyph(glyph(OpPlace, er, 4093, 1, 1'b0), 1'b0, '0);
      end
      1: begin
        // edge limit below the smallest page
        wait_drained();
        write_reg(REG_ATLAS_LIMIT, 32'd63);
        send_glyph(glyph(OpPlace, er, 1, 1, 1'b0), 1'b0, '0);
      end
      2: begin
        // close with the page count used up
        fill_pages(er);
        send_glyph(glyph(OpPlace, er, 1, 1, 1'b0), 1'b0, '0);
        send_glyph(glyph(OpClose, er, 0, 0, 1'b0), 1'b0, '0);
      end
      3: begin
        // full page with the page count used up: no close reply
        fill_pages(er);
        send_glyph(glyph(OpPlace, er, 1, 1, 1'b0), 1'b0, '0);
        send_glyph(glyph(OpPlace, er, 4092, 4092, 1'b0), 1'b0, '0);
      end
      default: begin
        // page closed under wide padding leaves its cursor there; with the
        // padding shrunk a tall glyph no longer fits the empty page
        wait_drained();
        write_reg(REG_PADDING, 32'd255);
        send_glyph(glyph(OpPlace, er, 1, 1, 1'b0), 1'b0, '0);
        send_glyph(glyph(OpClose, er, 0, 0, 1'b0), 1'b0, '0);
        wait_drained();
        write_reg(REG_PADDING, 32'd0);
        send_glyph(glyph(OpPlace, er, 4090, 4000, 1'b0), 1'b0, '0);
      end
    endcase
    repeat (40) send_glyph(glyph(1'($urandom), 1'($urandom), $urandom, $urandom, 1'($urandom)),
                           1'b0, '0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard, well beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
